// ===== hdl/iol_pkg.sv =====
// Package for the indexed ordered list: operation and status codes, field widths
// and the result record passed from the sequencer to the top level.
// Used by iol_ctrl and the top level; depends on nothing.
package iol_pkg;

   localparam int OP_W  = 3;
   localparam int VAL_W = 32;
   localparam int POS_W = 5;
   localparam int LEN_W = 5;
   localparam int ST_W  = 2;

   localparam int DEF_CAPACITY = 16;

   localparam logic [OP_W-1:0] OP_ADD_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT    = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
   localparam logic [OP_W-1:0] OP_READ      = 3'd4;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic                    valid;
      logic signed [VAL_W-1:0] read_value;
      logic [LEN_W-1:0]        length;
      logic [ST_W-1:0]         status;
   } res_type;

endpackage

// ===== hdl/iol_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. Depends on nothing.
module iol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/iol_ctrl.sv =====
// Sequencer of the indexed ordered list: decodes an operation, checks it against
// the entry count and moves entries through the RAM one per cycle.
// Depends on iol_pkg; drives one iol_ram instance held by the top level.
module iol_ctrl #(
   parameter int CAPACITY = iol_pkg::DEF_CAPACITY
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [iol_pkg::OP_W-1:0]        in_operation,
   input  logic signed [iol_pkg::VAL_W-1:0] in_value,
   input  logic [iol_pkg::POS_W-1:0]       in_position,
   output logic                            ram_we,
   output logic [$clog2(CAPACITY)-1:0]     ram_waddr,
   output logic [iol_pkg::VAL_W-1:0]       ram_wdata,
   output logic                            ram_re,
   output logic [$clog2(CAPACITY)-1:0]     ram_raddr,
   input  logic [iol_pkg::VAL_W-1:0]       ram_rdata,
   output iol_pkg::res_type                res,
   input  logic                            res_ready
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > iol_pkg::POS_W) ? CNT_W : iol_pkg::POS_W;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SH_INS   = 3'd1;
   localparam logic [2:0] S_INS_FIN  = 3'd2;
   localparam logic [2:0] S_REM_HEAD = 3'd3;
   localparam logic [2:0] S_SH_REM   = 3'd4;
   localparam logic [2:0] S_RD_WAIT  = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [ADDR_W-1:0]            cur_ff, cur_in;
   logic [ADDR_W-1:0]            lo_ff, lo_in;
   logic [iol_pkg::VAL_W-1:0]    val_ff, val_in;
   logic [iol_pkg::VAL_W-1:0]    rd_ff, rd_in;
   logic [iol_pkg::ST_W-1:0]     st_ff, st_in;

   logic [CMP_W-1:0]  cnt_w;
   logic [CMP_W-1:0]  pos_w;
   logic [CMP_W-1:0]  ins_pos;
   logic [ADDR_W-1:0] last_addr;
   logic [CNT_W-1:0]  count_dec;
   logic              full;
   logic              is_insert;

   assign cnt_w     = CMP_W'(count_ff);
   assign pos_w     = CMP_W'(in_position);
   assign full      = (count_ff >= CNT_W'(CAPACITY));
   assign count_dec = count_ff - CNT_W'(1);
   assign last_addr = count_dec[ADDR_W-1:0];
   assign in_ready  = (state_ff == S_IDLE);

   always_comb begin
      is_insert = 1'b0;
      ins_pos   = '0;
      unique case (in_operation)
         iol_pkg::OP_ADD_FRONT: begin
            is_insert = 1'b1;
            ins_pos   = '0;
         end
         iol_pkg::OP_ADD_BACK: begin
            is_insert = 1'b1;
            ins_pos   = cnt_w;
         end
         iol_pkg::OP_INSERT: begin
            is_insert = 1'b1;
            ins_pos   = pos_w;
         end
         default: begin
            is_insert = 1'b0;
            ins_pos   = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cur_in    = cur_ff;
      lo_in     = lo_ff;
      val_in    = val_ff;
      rd_in     = rd_ff;
      st_in     = st_ff;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               rd_in    = '0;
               st_in    = iol_pkg::ST_OK;
               val_in   = in_value;
               state_in = S_DONE;
               if (is_insert) begin
                  if (full) begin
                     st_in = iol_pkg::ST_FULL;
                  end else if (ins_pos > cnt_w) begin
                     st_in = iol_pkg::ST_RANGE;
                  end else if (ins_pos == cnt_w) begin
                     // Append: no entry moves, write straight into the free slot.
                     ram_we    = 1'b1;
                     ram_waddr = ins_pos[ADDR_W-1:0];
                     ram_wdata = in_value;
                     count_in  = count_ff + CNT_W'(1);
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = last_addr;
                     cur_in    = last_addr;
                     lo_in     = ins_pos[ADDR_W-1:0];
                     state_in  = S_SH_INS;
                  end
               end else if (in_operation == iol_pkg::OP_REMOVE ||
                            in_operation == iol_pkg::OP_READ) begin
                  if (pos_w >= cnt_w) begin
                     st_in = iol_pkg::ST_RANGE;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = pos_w[ADDR_W-1:0];
                     lo_in     = pos_w[ADDR_W-1:0];
                     state_in  = (in_operation == iol_pkg::OP_REMOVE) ? S_REM_HEAD
                                                                      : S_RD_WAIT;
                  end
               end
            end
         end
         S_SH_INS: begin
            // Entry at cur moves one place back while the next one is fetched.
            ram_we    = 1'b1;
            ram_waddr = cur_ff + ADDR_W'(1);
            ram_wdata = ram_rdata;
            if (cur_ff == lo_ff) begin
               state_in = S_INS_FIN;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = cur_ff - ADDR_W'(1);
               cur_in    = cur_ff - ADDR_W'(1);
            end
         end
         S_INS_FIN: begin
            ram_we    = 1'b1;
            ram_waddr = lo_ff;
            ram_wdata = val_ff;
            count_in  = count_ff + CNT_W'(1);
            state_in  = S_DONE;
         end
         S_REM_HEAD: begin
            rd_in = ram_rdata;
            if (lo_ff == last_addr) begin
               count_in = count_dec;
               state_in = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = lo_ff + ADDR_W'(1);
               cur_in    = lo_ff + ADDR_W'(1);
               state_in  = S_SH_REM;
            end
         end
         S_SH_REM: begin
            ram_we    = 1'b1;
            ram_waddr = cur_ff - ADDR_W'(1);
            ram_wdata = ram_rdata;
            if (cur_ff == last_addr) begin
               count_in = count_dec;
               state_in = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = cur_ff + ADDR_W'(1);
               cur_in    = cur_ff + ADDR_W'(1);
            end
         end
         S_RD_WAIT: begin
            rd_in    = ram_rdata;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      lo_ff  <= lo_in;
      val_ff <= val_in;
      rd_ff  <= rd_in;
      st_ff  <= st_in;
   end

   logic [CMP_W-1:0] len_w;
   assign len_w = CMP_W'(count_ff);

   assign res.valid      = (state_ff == S_DONE);
   assign res.read_value = rd_ff;
   assign res.length     = len_w[iol_pkg::LEN_W-1:0];
   assign res.status     = st_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |-> state_ff == S_DONE)
      else $error("entry count changed outside the end of an operation");

   a_no_same_addr: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> ram_waddr != ram_raddr)
      else $error("RAM read and write hit the same entry");

   a_ins_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SH_INS) |-> (cur_ff >= lo_ff && CNT_W'(cur_ff) < count_ff))
      else $error("insert cursor left the shifted span");

   a_rem_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SH_REM) |-> (cur_ff > lo_ff && cur_ff <= last_addr))
      else $error("remove cursor left the shifted span");

endmodule

// ===== hdl/indexed_ordered_list_top.sv =====
// Top level of the indexed ordered list: stream ports, output register, the
// entry RAM and the operation sequencer. Depends on iol_pkg, iol_ram, iol_ctrl.
//
// Channel   Direction  Payload (tdata, lowest bit first)
// req_      in         operation[2:0], value[34:3], position[39:35]
// rsp_      out        read_value[31:0], length[36:32], status[38:37], zero[39]
//
// One operation is handled at a time. An error, an unused code or an add or insert
// that lands at the end of the list moves no entry; a read waits for the RAM data.
// Any other add or insert at position p moves the count - p entries from p on one
// place back, and a remove at p the count - p - 1 entries behind it one place
// forward, where count is the length before the operation; the single RAM moves one
// entry a cycle. Reset empties the list at once; the RAM contents are not cleared.
// A finished result waits in the output register, so a new request transfer is
// taken while the previous response is stalled.
module indexed_ordered_list_top #(
   parameter int CAPACITY = iol_pkg::DEF_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // operation, value, position
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // read_value, length, status, one zero pad bit
);

   localparam int ADDR_W = $clog2(CAPACITY);

   // RAM connections between the sequencer and the entry store.
   logic                          ram_we;
   logic [ADDR_W-1:0]             ram_waddr;
   logic [iol_pkg::VAL_W-1:0]     ram_wdata;
   logic                          ram_re;
   logic [ADDR_W-1:0]             ram_raddr;
   logic [iol_pkg::VAL_W-1:0]     ram_rdata;

   iol_pkg::res_type              res;
   logic                          res_ready;

   // Response register: rsp_valid_ff marks a result waiting for its transfer.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [39:0]                   rsp_data_ff, rsp_data_in;

   iol_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_operation (req_tdata[2:0]),
      .in_value     (req_tdata[34:3]),
      .in_position  (req_tdata[39:35]),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_re       (ram_re),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata),
      .res          (res),
      .res_ready    (res_ready)
   );

   iol_ram #(
      .WIDTH(iol_pkg::VAL_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // The sequencer may hand over its result whenever the register is empty or
   // its current content leaves in this cycle.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res.valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, res.status, res.length, res.read_value};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending response overwritten");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken before the first finished");

   a_res_held: assert property (@(posedge clock) disable iff (reset)
      (res.valid && !res_ready) |=> res.valid)
      else $error("finished result withdrawn before hand-over");

endmodule
